// File: src/cae_pkg.sv
// Shared types and codes for the clip animation easing evaluator.
`default_nettype none
package cae_pkg;

  typedef enum logic [2:0] {
    REG_ENT_PRESET = 3'd0,
    REG_ENT_TICKS  = 3'd1,
    REG_EXT_PRESET = 3'd2,
    REG_EXT_TICKS  = 3'd3,
    REG_CLIP_TICKS = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PRE_NONE   = 4'd0,
    PRE_FADE   = 4'd1,
    PRE_UP     = 4'd2,
    PRE_DOWN   = 4'd3,
    PRE_LEFT   = 4'd4,
    PRE_RIGHT  = 4'd5,
    PRE_POP    = 4'd6,
    PRE_ZOOM   = 4'd7,
    PRE_SPIN   = 4'd8,
    PRE_TYPING = 4'd9
  } preset_e;

  localparam int unsigned TICK_W = 31;
  localparam int unsigned SPIN_Q88 = 120 * 256;

  // one progress lane inside a divider cell
  typedef struct packed {
    logic              fixed;     // progress settled before division
    logic              fixed_one; // settled value is one, else zero
    logic [TICK_W-1:0] rem;
  } lane_t;

  typedef struct packed {
    logic  valid;
    lane_t ent;
    lane_t ext;
  } cell_t;

  typedef struct packed {
    logic signed [15:0] shift_x;
    logic signed [15:0] shift_y;
    logic [16:0]        zoom_factor;
    logic signed [15:0] turn_angle;
    logic [16:0]        alpha;
    logic [16:0]        reveal_amount;
  } xform_t;

endpackage
`default_nettype wire

// File: src/cae_if.sv
// Handshake channels for playhead input and transform output.
`default_nettype none
interface cae_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] playhead_offset;
  modport source (output valid, output playhead_offset, input ready);
  modport sink (input valid, input playhead_offset, output ready);
endinterface

interface cae_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] shift_x;
  logic signed [15:0] shift_y;
  logic [16:0]        zoom_factor;
  logic signed [15:0] turn_angle;
  logic [16:0]        alpha;
  logic [16:0]        reveal_amount;
  logic               text_reveal_active;
  modport source (output valid, output shift_x, output shift_y, output zoom_factor,
                  output turn_angle, output alpha, output reveal_amount,
                  output text_reveal_active, input ready);
  modport sink (input valid, input shift_x, input shift_y, input zoom_factor,
                input turn_angle, input alpha, input reveal_amount,
                input text_reveal_active, output ready);
endinterface
`default_nettype wire

// File: src/cae_div_cell.sv
// One restoring-division cell: one quotient bit for each progress lane.
`default_nettype none
module cae_div_cell
  import cae_pkg::*;
#(
  parameter int unsigned QW = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic [TICK_W-1:0] ent_ticks,
  input  wire logic [TICK_W-1:0] ext_ticks,
  input  wire cell_t             din,
  input  wire logic [QW-1:0]     q_ent_in,
  input  wire logic [QW-1:0]     q_ext_in,
  output cell_t                  dout,
  output logic [QW-1:0]          q_ent,
  output logic [QW-1:0]          q_ext
);

  logic [TICK_W:0]   ent_r2, ext_r2, ent_diff, ext_diff;
  logic              ent_ge, ext_ge;
  cell_t             nxt;

  always_comb begin
    ent_r2   = {din.ent.rem, 1'b0};
    ext_r2   = {din.ext.rem, 1'b0};
    ent_diff = ent_r2 - {1'b0, ent_ticks};
    ext_diff = ext_r2 - {1'b0, ext_ticks};
    ent_ge   = ent_r2 >= {1'b0, ent_ticks};
    ext_ge   = ext_r2 >= {1'b0, ext_ticks};
    nxt      = din;
    nxt.ent.rem = ent_ge ? ent_diff[TICK_W-1:0] : ent_r2[TICK_W-1:0];
    nxt.ext.rem = ext_ge ? ext_diff[TICK_W-1:0] : ext_r2[TICK_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout  <= nxt;
      q_ent <= {q_ent_in[QW-2:0], ent_ge};
      q_ext <= {q_ext_in[QW-2:0], ext_ge};
    end
  end

endmodule
`default_nettype wire

// File: src/cae_ease.sv
// Easing pipeline: picks the active progress and evaluates the preset curve.
`default_nettype none
module cae_ease
  import cae_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [FRAC_BITS:0] t_ent,
  input  wire logic [FRAC_BITS:0] t_ext,
  input  wire logic [3:0]         ent_preset,
  input  wire logic [3:0]         ext_preset,
  input  wire logic               clip_zero,
  output logic                    res_valid,
  output xform_t                  res
);

  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned NW  = F + 2;
  localparam int unsigned PW  = 2 * F + 6;
  localparam longint ONE_L    = longint'(1) <<< F;
  localparam longint SLIDE_L  = (35 * ONE_L + 50) / 100;
  localparam longint ZF_L     = (55 * ONE_L + 50) / 100;
  localparam longint CAP_L    = (112 * ONE_L + 50) / 100;
  localparam longint C1_L     = (170158 * ONE_L + 50000) / 100000;
  localparam longint C3_L     = C1_L + ONE_L;
  localparam logic [PW-1:0] ONE   = PW'(ONE_L);
  localparam logic [PW-1:0] HALF  = PW'(ONE_L >>> 1);
  localparam logic [PW-1:0] SLIDE = PW'(SLIDE_L);
  localparam logic [PW-1:0] ZF    = PW'(ZF_L);
  localparam logic [PW-1:0] ZR    = PW'(ONE_L - ZF_L);
  localparam logic [PW-1:0] CAP   = PW'(CAP_L);
  localparam logic [PW-1:0] C1    = PW'(C1_L);
  localparam logic [PW-1:0] C3    = PW'(C3_L);
  localparam logic [PW-1:0] SPIN  = PW'(SPIN_Q88);
  localparam int unsigned SHR = (F > 16) ? F - 16 : 0;
  localparam int unsigned SHL = (F < 16) ? 16 - F : 0;
  localparam int unsigned CW  = NW + SHL + 1;
  localparam logic [CW-1:0] RND = (F > 16) ? CW'(longint'(1) <<< (F - 17)) : '0;

  // fixed point at FRAC_BITS to Q16, half up on the magnitude
  function automatic logic [16:0] to_q16(input logic [NW-1:0] m);
    logic [CW-1:0] x;
    x = (CW'(m) + RND) >> SHR;
    x = x << SHL;
    return x[16:0];
  endfunction

  // stage registers
  logic              v1, v2, v3, v4, v5;
  logic [3:0]        p1, p2, p3, p4;
  logic [NW-1:0]     t1, t2, t3, t4;
  logic [NW-1:0]     u1, u2;
  logic [NW-1:0]     sq3, sq3d, cube3;
  logic [NW-1:0]     eased4, slide4, c3c4, c1s4, zease4;
  logic [14:0]       turn4;

  logic              sel_ext;
  logic [PW-1:0]     sq_p, cube_p, slide_p, c3c_p, c1s_p, zease_p, turn_p;
  logic [PW-1:0]     eased_w, back, zpop_p, zpop;
  logic [NW-1:0]     sx_m, sy_m, zoom_m, alpha_m, reveal_m;
  logic              sx_neg, sy_neg;
  logic [14:0]       turn_m;
  logic [16:0]       sx_q, sy_q;
  xform_t            res_next;

  always_comb begin
    sel_ext = t_ext < t_ent;
    sq_p    = (PW'(u1) * PW'(u1) + HALF) >> F;
    cube_p  = (PW'(sq3) * PW'(u2) + HALF) >> F;
    eased_w = ONE - PW'(cube3);
    slide_p = (PW'(cube3) * SLIDE + HALF) >> F;
    c3c_p   = (PW'(cube3) * C3 + HALF) >> F;
    c1s_p   = (PW'(sq3d) * C1 + HALF) >> F;
    zease_p = ZF + ((eased_w * ZR + HALF) >> F);
    turn_p  = (PW'(cube3) * SPIN + HALF) >> F;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // pick the animation further from rest; a zero clip is rest
      p1 <= clip_zero ? PRE_NONE : (sel_ext ? ext_preset : ent_preset);
      t1 <= NW'(sel_ext ? t_ext : t_ent);
      u1 <= NW'(ONE) - NW'(sel_ext ? t_ext : t_ent);
      p2 <= p1; t2 <= t1; u2 <= u1; sq3 <= sq_p[NW-1:0];
      p3 <= p2; t3 <= t2; cube3 <= cube_p[NW-1:0];
      // carry the square alongside the cube
      sq3d <= sq3;
      p4 <= p3; t4 <= t3;
      eased4 <= eased_w[NW-1:0];
      slide4 <= slide_p[NW-1:0];
      c3c4   <= c3c_p[NW-1:0];
      c1s4   <= c1s_p[NW-1:0];
      zease4 <= zease_p[NW-1:0];
      turn4  <= turn_p[14:0];
      res    <= res_next;
    end
  end

  always_comb begin
    back = ONE - PW'(c3c4) + PW'(c1s4);
    if (back[PW-1]) begin
      back = '0;
    end
    zpop_p = ZF + ((back * ZR + HALF) >> F);
    zpop   = (zpop_p > CAP) ? CAP : zpop_p;
    sx_m = '0; sy_m = '0; sx_neg = 1'b0; sy_neg = 1'b0;
    zoom_m = NW'(ONE); turn_m = '0; alpha_m = NW'(ONE); reveal_m = NW'(ONE);
    case (p4)
      PRE_FADE:   alpha_m = t4;
      PRE_UP:     begin sy_m = slide4; alpha_m = eased4; end
      PRE_DOWN:   begin sy_m = slide4; sy_neg = 1'b1; alpha_m = eased4; end
      PRE_LEFT:   begin sx_m = slide4; alpha_m = eased4; end
      PRE_RIGHT:  begin sx_m = slide4; sx_neg = 1'b1; alpha_m = eased4; end
      PRE_POP:    begin zoom_m = zpop[NW-1:0]; alpha_m = eased4; end
      PRE_ZOOM:   begin zoom_m = zease4; alpha_m = eased4; end
      PRE_SPIN:   begin
        turn_m = turn4; zoom_m = zease4; alpha_m = eased4;
      end
      PRE_TYPING: reveal_m = t4;
      default:    ;
    endcase
    sx_q = to_q16(sx_m);
    sy_q = to_q16(sy_m);
    res_next.shift_x       = sx_neg ? -sx_q[15:0] : sx_q[15:0];
    res_next.shift_y       = sy_neg ? -sy_q[15:0] : sy_q[15:0];
    res_next.zoom_factor   = to_q16(zoom_m);
    res_next.turn_angle    = -{1'b0, turn_m};
    res_next.alpha         = to_q16(alpha_m);
    res_next.reveal_amount = to_q16(reveal_m);
  end

  assign res_valid = v5;

endmodule
`default_nettype wire

// File: src/clip_animation_easing_evaluator_top.sv
// Top level of the clip animation easing evaluator.
`default_nettype none
// Takes one playhead offset per cycle and returns that clip's transform
// (shift, zoom, turn, opacity, text reveal) one item per cycle. Each item
// passes an entry register that settles the saturated cases, the row of
// divider cells (each cell resolves one quotient bit of both the entrance
// and the exit progress), the easing arithmetic stages and one output
// register. The whole pipe advances together whenever the output register
// is empty or being taken, so a stall on the output holds every stage and
// drops ready on the input. Configuration is sampled live by the entry
// stage, the divider cells, the first easing stage and the output register,
// so write it only while no transaction is in flight.
module clip_animation_easing_evaluator_top
  import cae_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [30:0] cfg_data,
  cae_in_if.sink           in_ch,
  cae_out_if.source        out_ch
);

  localparam int unsigned F = FRAC_BITS;

  // configuration registers
  logic [3:0]        ent_preset, ext_preset;
  logic [TICK_W-1:0] ent_ticks, ext_ticks, clip_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_preset <= '0; ext_preset <= '0;
      ent_ticks  <= '0; ext_ticks  <= '0; clip_ticks <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENT_PRESET: ent_preset <= cfg_data[3:0];
        REG_ENT_TICKS:  ent_ticks  <= cfg_data;
        REG_EXT_PRESET: ext_preset <= cfg_data[3:0];
        REG_EXT_TICKS:  ext_ticks  <= cfg_data;
        REG_CLIP_TICKS: clip_ticks <= cfg_data;
        default:        ;
      endcase
    end
  end

  // advance the whole pipe when the output slot is free or being drained
  logic adv;
  logic out_valid;
  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;

  // entry stage: settle disabled and saturated progress, load remainders
  logic               ent_en, ext_en, ent_le0, ent_ge, ext_le0, ext_ge;
  logic signed [32:0] ext_num;
  cell_t              entry_next, entry;

  always_comb begin
    ent_en  = (ent_preset != PRE_NONE) && (ent_ticks != '0);
    ext_en  = (ext_preset != PRE_NONE) && (ext_ticks != '0);
    ent_le0 = in_ch.playhead_offset[31] || (in_ch.playhead_offset == '0);
    ent_ge  = !in_ch.playhead_offset[31] && (in_ch.playhead_offset[30:0] >= ent_ticks);
    ext_num = $signed({2'b00, clip_ticks})
            - $signed({in_ch.playhead_offset[31], in_ch.playhead_offset});
    ext_le0 = ext_num[32] || (ext_num == '0);
    ext_ge  = !ext_num[32] && (ext_num[31:0] >= {1'b0, ext_ticks});
    entry_next.valid         = in_ch.valid;
    entry_next.ent.fixed     = !ent_en || ent_le0 || ent_ge;
    entry_next.ent.fixed_one = !ent_en || !ent_le0;
    entry_next.ent.rem       = in_ch.playhead_offset[30:0];
    entry_next.ext.fixed     = !ext_en || ext_le0 || ext_ge;
    entry_next.ext.fixed_one = !ext_en || !ext_le0;
    entry_next.ext.rem       = ext_num[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (adv) begin
      entry <= entry_next;
    end
  end

  // row of divider cells, one quotient bit each
  cell_t        chain [0:F];
  logic [F-1:0] q_ent [0:F];
  logic [F-1:0] q_ext [0:F];

  assign chain[0] = entry;
  assign q_ent[0] = '0;
  assign q_ext[0] = '0;

  for (genvar i = 0; i < F; i++) begin : g_cell
    cae_div_cell #(.QW(F)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .ent_ticks (ent_ticks),
      .ext_ticks (ext_ticks),
      .din       (chain[i]),
      .q_ent_in  (q_ent[i]),
      .q_ext_in  (q_ext[i]),
      .dout      (chain[i+1]),
      .q_ent     (q_ent[i+1]),
      .q_ext     (q_ext[i+1])
    );
  end

  // settled lanes override the quotient
  logic [F:0] t_ent, t_ext;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  always_comb begin
    t_ent = chain[F].ent.fixed ? (chain[F].ent.fixed_one ? ONE : '0) : {1'b0, q_ent[F]};
    t_ext = chain[F].ext.fixed ? (chain[F].ext.fixed_one ? ONE : '0) : {1'b0, q_ext[F]};
  end

  logic   res_valid;
  xform_t res;

  cae_ease #(.FRAC_BITS(F)) u_ease (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .in_valid   (chain[F].valid),
    .t_ent      (t_ent),
    .t_ext      (t_ext),
    .ent_preset (ent_preset),
    .ext_preset (ext_preset),
    .clip_zero  (clip_ticks == '0),
    .res_valid  (res_valid),
    .res        (res)
  );

  // output register; typewriter flag follows configuration alone
  xform_t out_res;
  logic   out_typing;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res    <= res;
      out_typing <= ((ent_preset == PRE_TYPING) && (ent_ticks != '0))
                 || ((ext_preset == PRE_TYPING) && (ext_ticks != '0));
    end
  end

  assign out_ch.valid              = out_valid;
  assign out_ch.shift_x            = out_res.shift_x;
  assign out_ch.shift_y            = out_res.shift_y;
  assign out_ch.zoom_factor        = out_res.zoom_factor;
  assign out_ch.turn_angle         = out_res.turn_angle;
  assign out_ch.alpha              = out_res.alpha;
  assign out_ch.reveal_amount      = out_res.reveal_amount;
  assign out_ch.text_reveal_active = out_typing;

endmodule
`default_nettype wire

// File: src/cae_checker.sv
// Port-level checks for the easing evaluator and their binding.
`default_nettype none
module cae_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [16:0] alpha,
  input wire logic [16:0] reveal_amount,
  input wire logic [16:0] zoom_factor
);

  // a held result keeps valid
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a blocked output stalls the input side
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output blocked");

  // nothing comes out straight after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown after reset");

  // opacity, reveal and zoom stay in their ranges
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> alpha <= 17'd65536 && reveal_amount <= 17'd65536
                  && zoom_factor <= 17'd73400)
    else $error("result out of range");

endmodule

bind clip_animation_easing_evaluator_top cae_checker u_cae_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .alpha         (out_ch.alpha),
  .reveal_amount (out_ch.reveal_amount),
  .zoom_factor   (out_ch.zoom_factor)
);
`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the clip animation easing evaluator.
`timescale 1ns / 100ps

module tb
  import cae_pkg::*;
();

  localparam int FRAC = 16;
  localparam longint ONE_Q = 64'sd1 << FRAC;
  localparam longint HALF_Q = 64'sd1 << (FRAC - 1);
  localparam longint SLIDE_Q = (35 * ONE_Q + 50) / 100;
  localparam longint ZOOM_FROM_Q = (55 * ONE_Q + 50) / 100;
  localparam longint POP_CAP_Q = (112 * ONE_Q + 50) / 100;
  localparam longint BACK_C1_Q = (170158 * ONE_Q + 50000) / 100000;
  localparam longint BACK_C3_Q = BACK_C1_Q + ONE_Q;
  localparam logic [3:0] UNKNOWN_PRESET = 4'd12;
  localparam logic [30:0] TICK_MAX = 31'h7fffffff;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [16:0]        zm;
    logic signed [15:0] tn;
    logic [16:0]        al;
    logic [16:0]        rv;
    logic               tr;
  } pose_t;

  typedef struct {
    logic [3:0]  ep;
    logic [30:0] et;
    logic [3:0]  xp;
    logic [30:0] xt;
    logic [30:0] ct;
  } clip_cfg_t;

  typedef struct {
    clip_cfg_t          c;
    logic signed [31:0] off;
    bit                 typed;
    pose_t              want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  cae_in_if  in_ch ();
  cae_out_if out_ch ();

  clip_animation_easing_evaluator_top #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Shadow of the clip registers, as the block holds them.
  clip_cfg_t shadow = '{default: '0};

  pose_t pending_poses[$];
  int    errors = 0;
  int    sent = 0;
  int    cycles = 0;
  bit    calm = 1'b0;     // no idling on either side while set
  bit    hold_req = 1'b0; // ask the receiver for a long hold-off

  function automatic longint qmul(longint a, longint b);
    return (a * b + HALF_Q) >>> FRAC;
  endfunction

  function automatic longint sat_progress(longint num, longint den);
    if (num <= 0) return 0;
    if (num >= den) return ONE_Q;
    return (num * ONE_Q) / den;
  endfunction

  // Convert from the internal fraction width to Q16, rounding half up on magnitude.
  function automatic longint to_q16(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    if (FRAC > 16) m = (m + (64'sd1 <<< (FRAC - 17))) >>> (FRAC - 16);
    else if (FRAC < 16) m = m <<< (16 - FRAC);
    return (v < 0) ? -m : m;
  endfunction

  function automatic pose_t predict_pose(logic signed [31:0] off);
    longint o, in_t, out_t, t, u, sq, cube, eased, back;
    longint sx, sy, zm, tn, al, rv;
    logic [3:0] p;
    pose_t r;
    o = off;
    sx = 0; sy = 0; zm = ONE_Q; tn = 0; al = ONE_Q; rv = ONE_Q;
    if (shadow.ct != 0) begin
      in_t = ONE_Q;
      out_t = ONE_Q;
      if (shadow.ep != PRE_NONE && shadow.et != 0) in_t = sat_progress(o, shadow.et);
      if (shadow.xp != PRE_NONE && shadow.xt != 0)
        out_t = sat_progress(longint'(shadow.ct) - o, shadow.xt);
      // the exit takes over only when strictly further from rest
      if (out_t < in_t) begin
        p = shadow.xp; t = out_t;
      end else begin
        p = shadow.ep; t = in_t;
      end
      u = ONE_Q - t;
      sq = qmul(u, u);
      cube = qmul(sq, u);
      eased = ONE_Q - cube;
      case (p)
        PRE_FADE: al = t;
        PRE_UP: begin sy = qmul(cube, SLIDE_Q); al = eased; end
        PRE_DOWN: begin sy = -qmul(cube, SLIDE_Q); al = eased; end
        PRE_LEFT: begin sx = qmul(cube, SLIDE_Q); al = eased; end
        PRE_RIGHT: begin sx = -qmul(cube, SLIDE_Q); al = eased; end
        PRE_POP: begin
          back = ONE_Q - qmul(BACK_C3_Q, cube) + qmul(BACK_C1_Q, sq);
          if (back < 0) back = 0;
          zm = ZOOM_FROM_Q + qmul(ONE_Q - ZOOM_FROM_Q, back);
          if (zm > POP_CAP_Q) zm = POP_CAP_Q;
          al = eased;
        end
        PRE_ZOOM: begin zm = ZOOM_FROM_Q + qmul(ONE_Q - ZOOM_FROM_Q, eased); al = eased; end
        PRE_SPIN: begin
          tn = -((cube * SPIN_Q88 + HALF_Q) >>> FRAC);
          zm = ZOOM_FROM_Q + qmul(ONE_Q - ZOOM_FROM_Q, eased);
          al = eased;
        end
        PRE_TYPING: rv = t;
        default: ;
      endcase
    end
    r.sx = 16'(to_q16(sx));
    r.sy = 16'(to_q16(sy));
    r.zm = 17'(to_q16(zm));
    r.tn = 16'(tn);
    r.al = 17'(to_q16(al));
    r.rv = 17'(to_q16(rv));
    r.tr = (shadow.ep == PRE_TYPING && shadow.et != 0) ||
           (shadow.xp == PRE_TYPING && shadow.xt != 0);
    return r;
  endfunction

  // Write all five registers on consecutive edges; the block must be idle.
  task automatic load_clip(clip_cfg_t c);
    cfg_reg_e idx[5];
    logic [30:0] val[5];
    idx = '{REG_ENT_PRESET, REG_ENT_TICKS, REG_EXT_PRESET, REG_EXT_TICKS, REG_CLIP_TICKS};
    val = '{31'(c.ep), c.et, 31'(c.xp), c.xt, c.ct};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    shadow = c;
  endtask

  // Offer one playhead and hold it until the transaction completes.
  task automatic offer(logic signed [31:0] off, bit typed, pose_t want);
    in_ch.valid <= 1'b1;
    in_ch.playhead_offset <= off;
    do @(posedge clk); while (!in_ch.ready);
    pending_poses.push_back(typed ? want : predict_pose(off));
    sent++;
    if (sent == 500) hold_req = 1'b1;
    // random gap after the transaction, never while calm
    if (!calm && $urandom_range(0, 99) < 25) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [30:0] pick_ticks(int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return TICK_MAX;
    return 31'($urandom_range(1, hi));
  endfunction

  function automatic logic [3:0] pick_preset();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(10, 15));
    return 4'($urandom_range(PRE_NONE, PRE_TYPING));
  endfunction

  function automatic pose_t rest(bit tr);
    return '{sx: 0, sy: 0, zm: 17'(ONE_Q), tn: 0, al: 17'(ONE_Q), rv: 17'(ONE_Q), tr: tr};
  endfunction

  // Receiver: random stalls, calm stretch, one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        for (int n = 0; n < 300; n++) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 25);
    end
  end

  // Compare every completed output transaction with the oldest prediction.
  always @(posedge clk) begin
    pose_t w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_poses.size() == 0) begin
        $error("unexpected transform: shift_x=%0d", out_ch.shift_x);
        errors++;
      end else begin
        w = pending_poses.pop_front();
        if (out_ch.shift_x !== w.sx) begin
          $error("shift_x expected %0d got %0d", w.sx, out_ch.shift_x); errors++;
        end
        if (out_ch.shift_y !== w.sy) begin
          $error("shift_y expected %0d got %0d", w.sy, out_ch.shift_y); errors++;
        end
        if (out_ch.zoom_factor !== w.zm) begin
          $error("zoom_factor expected %0d got %0d", w.zm, out_ch.zoom_factor); errors++;
        end
        if (out_ch.turn_angle !== w.tn) begin
          $error("turn_angle expected %0d got %0d", w.tn, out_ch.turn_angle); errors++;
        end
        if (out_ch.alpha !== w.al) begin
          $error("alpha expected %0d got %0d", w.al, out_ch.alpha); errors++;
        end
        if (out_ch.reveal_amount !== w.rv) begin
          $error("reveal_amount expected %0d got %0d", w.rv, out_ch.reveal_amount); errors++;
        end
        if (out_ch.text_reveal_active !== w.tr) begin
          $error("text_reveal_active expected %0d got %0d", w.tr,
                 out_ch.text_reveal_active);
          errors++;
        end
      end
    end
  end

  // Watchdog: abandon the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    clip_cfg_t c;
    pose_t none;
    longint o;
    int n;
    none = rest(1'b0);
    in_ch.valid = 1'b0;
    in_ch.playhead_offset = '0;

    // Directed rows: typed results where they are plain, otherwise predicted.
    rows.push_back('{'{PRE_NONE, 0, PRE_NONE, 0, 0}, 0, 1, rest(1'b0)});
    rows.push_back('{'{PRE_TYPING, 10, PRE_NONE, 0, 0}, 5, 1, rest(1'b1)});
    r = '{'{PRE_FADE, 100, PRE_NONE, 0, 1000}, 50, 1, rest(1'b0)}; r.want.al = 32768;
    rows.push_back(r);
    r.off = -5; r.want.al = 0; rows.push_back(r);
    r.off = 32'sh7fffffff; r.want.al = 17'(ONE_Q); rows.push_back(r);
    r.off = 32'sh80000000; r.want.al = 0; rows.push_back(r);
    r = '{'{PRE_UP, 100, PRE_NONE, 0, 1000}, 0, 1, rest(1'b0)};
    r.want.al = 0; r.want.sy = 16'(SLIDE_Q); rows.push_back(r);
    r.c.ep = PRE_DOWN; r.want.sy = -16'(SLIDE_Q); rows.push_back(r);
    r.c.ep = PRE_LEFT; r.want.sy = 0; r.want.sx = 16'(SLIDE_Q); rows.push_back(r);
    r.c.ep = PRE_RIGHT; r.want.sx = -16'(SLIDE_Q); rows.push_back(r);
    r = '{'{PRE_POP, 100, PRE_NONE, 0, 1000}, 0, 1, rest(1'b0)};
    r.want.al = 0; r.want.zm = 17'(ZOOM_FROM_Q); rows.push_back(r);
    r.c.ep = PRE_ZOOM; rows.push_back(r);
    r.c.ep = PRE_SPIN; r.want.tn = -16'(SPIN_Q88); rows.push_back(r);
    rows.push_back('{'{PRE_POP, 100, PRE_NONE, 0, 1000}, 30, 0, none});
    rows.push_back('{'{PRE_POP, 100, PRE_NONE, 0, 1000}, 60, 0, none});
    rows.push_back('{'{PRE_SPIN, 100, PRE_NONE, 0, 1000}, 37, 0, none});
    rows.push_back('{'{PRE_TYPING, 100, PRE_NONE, 0, 1000}, 25, 0, none});
    rows.push_back('{'{UNKNOWN_PRESET, 100, PRE_FADE, 100, 1000}, 10, 0, none});
    rows.push_back('{'{PRE_FADE, 100, PRE_FADE, 100, 1000}, 950, 0, none});
    rows.push_back('{'{PRE_FADE, 100, PRE_TYPING, 100, 1000}, 1200, 0, none});
    rows.push_back('{'{PRE_ZOOM, TICK_MAX, PRE_LEFT, TICK_MAX, TICK_MAX},
                    32'sh40000000, 0, none});
    rows.push_back('{'{PRE_UP, TICK_MAX, PRE_POP, TICK_MAX, TICK_MAX},
                    32'sh80000000, 0, none});
    rows.push_back('{'{4'd15, 1, 4'd15, 1, 1}, 1, 0, none});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      // the first row runs on the reset values
      if (i > 0) load_clip(rows[i].c);
      offer(rows[i].off, rows[i].typed, rows[i].want);
      drain();
    end

    // Random phases: fresh registers, then a burst of playheads around the clip.
    while (sent < 830) begin
      c.ep = pick_preset();
      c.xp = pick_preset();
      c.et = pick_ticks(300);
      c.xt = pick_ticks(300);
      c.ct = ($urandom_range(0, 19) == 0) ? 31'd0 :
             ($urandom_range(0, 9) == 0) ? TICK_MAX : 31'($urandom_range(1, 600));
      load_clip(c);
      calm = (sent >= 300 && sent < 450);
      n = $urandom_range(20, 60);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          o = $signed($urandom);
        end else begin
          o = longint'($urandom_range(0, 700)) - 50;
          if ($urandom_range(0, 1)) o = longint'(c.ct) - o;
        end
        offer(32'(o), 1'b0, none);
      end
      drain();
    end
    calm = 1'b0;

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
